FILE: hdl/sqlc_pkg.sv
// ----------------------------------------------------------------------------
// sqlc_pkg
// Shared types, constants and match functions of the SQL statement classifier.
// ----------------------------------------------------------------------------
package sqlc_pkg;

  localparam int unsigned PrefixDepth = 21;
  localparam int unsigned TailDepth   = 11;
  localparam int unsigned CntWidth    = $clog2(PrefixDepth + 1);
  // Widest keyword literal, one byte per character
  localparam int unsigned KwBits      = 8 * PrefixDepth;

  typedef logic [7:0] byte_t;
  typedef logic [CntWidth-1:0] cnt_t;
  typedef logic [KwBits-1:0] kw_t;
  typedef byte_t [PrefixDepth-1:0] prefix_arr_t;
  // Tail window: entry 0 is the newest byte
  typedef byte_t [TailDepth-1:0] tail_arr_t;

  typedef enum logic [4:0] {
    ClsBegin         = 5'd0,
    ClsCommit        = 5'd1,
    ClsRollback      = 5'd2,
    ClsSavepoint     = 5'd3,
    ClsWith          = 5'd4,
    ClsWindow        = 5'd5,
    ClsSetop         = 5'd6,
    ClsShow          = 5'd7,
    ClsSet           = 5'd8,
    ClsGrant         = 5'd9,
    ClsExplain       = 5'd10,
    ClsPrepare       = 5'd11,
    ClsExecute       = 5'd12,
    ClsPragma        = 5'd13,
    ClsReindex       = 5'd14,
    ClsCreateView    = 5'd15,
    ClsCreateTrigger = 5'd16,
    ClsDropTrigger   = 5'd17,
    ClsDropView      = 5'd18,
    ClsOltp          = 5'd19,
    ClsUnknown       = 5'd20
  } class_e;

  // Statement state as it stands after the current byte
  typedef struct packed {
    prefix_arr_t store;
    cnt_t        trimmed;
    logic        window_found;
    logic        setop_found;
  } sqlc_view_t;

  // Keyword literals sit right-justified: character i of an n-character
  // keyword is at bits [(n-1-i)*8 +: 8].
  function automatic logic prefix_hit(input prefix_arr_t st, input cnt_t cnt,
                                      input kw_t kw, input cnt_t len);
    logic ok;
    int   pos;
    ok = (cnt >= len);
    for (int i = 0; i < PrefixDepth; i++) begin
      if (i < int'(len)) begin
        pos = (int'(len) - 1 - i) * 8;
        if (st[i] != kw[pos +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Newest byte matches the last keyword character, and so on backwards
  function automatic logic tail_hit(input tail_arr_t win, input kw_t kw,
                                    input cnt_t len);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < TailDepth; k++) begin
      if (k < int'(len)) begin
        if (win[k] != kw[k*8 +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

FILE: hdl/sqlc_if.sv
// ----------------------------------------------------------------------------
// sqlc_in_if / sqlc_out_if
// Valid/ready channels carrying statement bytes in and class codes out.
// ----------------------------------------------------------------------------
interface sqlc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface sqlc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  statement_class;

  modport source (output valid, output statement_class, input ready);
  modport sink   (input valid, input statement_class, output ready);
endinterface

FILE: hdl/sqlc_track.sv
// ----------------------------------------------------------------------------
// sqlc_track
// Per-byte statement tracking: trimming, prefix store, tail window matches.
// ----------------------------------------------------------------------------
module sqlc_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         text_byte_i,
  input  logic               last_byte_i,
  output sqlc_pkg::sqlc_view_t view_o
);

  logic                  seen_q, seen_d;
  sqlc_pkg::cnt_t        cnt_q, cnt_d;
  sqlc_pkg::cnt_t        trim_q, trim_d;
  sqlc_pkg::prefix_arr_t store_q, store_d;
  sqlc_pkg::tail_arr_t   tail_q, tail_d;
  logic                  win_q, win_d;
  logic                  pend_q, pend_d;
  logic                  setop_q, setop_d;
  sqlc_pkg::byte_t       ub;
  logic                  blank;
  logic                  take;

  // Uppercase fold and whitespace detect
  always_comb begin
    ub = text_byte_i;
    if (text_byte_i >= 8'h61 && text_byte_i <= 8'h7A) ub = text_byte_i - 8'h20;
    blank = (ub == 8'h20) || (ub >= 8'h09 && ub <= 8'h0D);
    take  = seen_q || !blank;
  end

  // Next state for one byte
  always_comb begin
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    trim_d  = trim_q;
    store_d = store_q;
    tail_d  = tail_q;
    win_d   = win_q;
    pend_d  = pend_q;
    setop_d = setop_q;
    if (take) begin
      seen_d = 1'b1;
      if (cnt_q < sqlc_pkg::cnt_t'(sqlc_pkg::PrefixDepth)) begin
        store_d[cnt_q] = ub;
        cnt_d          = cnt_q + 1'b1;
      end
      if (!blank) trim_d = cnt_d;
      tail_d = {tail_q[sqlc_pkg::TailDepth-2:0], ub};
      if (!blank && pend_q) begin
        setop_d = 1'b1;
        pend_d  = 1'b0;
      end
      if (sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'(" OVER("), 5'd6) ||
          sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'(" OVER ("), 5'd7) ||
          sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'({"ROW_", "NUMBER("}), 5'd11) ||
          sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'("RANK("), 5'd5)) begin
        win_d = 1'b1;
      end
      if (sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'(" UNION "), 5'd7) ||
          sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'(" INTERSECT "), 5'd11) ||
          sqlc_pkg::tail_hit(tail_d, sqlc_pkg::kw_t'(" EXCEPT "), 5'd8)) begin
        pend_d = 1'b1;
      end
    end
  end

  assign view_o.store        = store_d;
  assign view_o.trimmed      = trim_d;
  assign view_o.window_found = win_d;
  assign view_o.setop_found  = setop_d;

  // Control state; the last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      cnt_q   <= '0;
      trim_q  <= '0;
      tail_q  <= '0;
      win_q   <= 1'b0;
      pend_q  <= 1'b0;
      setop_q <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        seen_q  <= 1'b0;
        cnt_q   <= '0;
        trim_q  <= '0;
        tail_q  <= '0;
        win_q   <= 1'b0;
        pend_q  <= 1'b0;
        setop_q <= 1'b0;
      end else begin
        seen_q  <= seen_d;
        cnt_q   <= cnt_d;
        trim_q  <= trim_d;
        tail_q  <= tail_d;
        win_q   <= win_d;
        pend_q  <= pend_d;
        setop_q <= setop_d;
      end
    end
  end

  // Prefix store, read only below the trimmed count
  always_ff @(posedge clk_i) begin
    if (step_i) store_q <= store_d;
  end

  a_trim_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trim_q <= cnt_q)
    else $error("trimmed count above stored count");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sqlc_pkg::cnt_t'(sqlc_pkg::PrefixDepth))
    else $error("prefix count past store depth");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> (cnt_q == '0) && !seen_q && !pend_q)
    else $error("state not cleared after last byte");

  a_empty_when_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (cnt_q == '0) && !win_q && !setop_q)
    else $error("state present before first non-blank byte");

endmodule

FILE: hdl/sqlc_classify.sv
// ----------------------------------------------------------------------------
// sqlc_classify
// Priority decode of the statement class from prefix, window and set-operation flags.
// ----------------------------------------------------------------------------
module sqlc_classify (
  input  sqlc_pkg::sqlc_view_t view_i,
  output sqlc_pkg::class_e     class_o
);

  typedef sqlc_pkg::kw_t kw_t;

  sqlc_pkg::prefix_arr_t st;
  sqlc_pkg::cnt_t        n;

  assign st = view_i.store;
  assign n  = view_i.trimmed;

  // First matching rule wins
  always_comb begin
    if (sqlc_pkg::prefix_hit(st, n, kw_t'("BEGIN"), 5'd5) ||
        sqlc_pkg::prefix_hit(st, n, kw_t'("START TRANSACTION"), 5'd17)) begin
      class_o = sqlc_pkg::ClsBegin;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("COMMIT"), 5'd6)) begin
      class_o = sqlc_pkg::ClsCommit;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("ROLLBACK"), 5'd8)) begin
      class_o = sqlc_pkg::ClsRollback;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("SAVEPOINT"), 5'd9) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("RELEASE SAVEPOINT"), 5'd17)) begin
      class_o = sqlc_pkg::ClsSavepoint;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("WITH"), 5'd4)) begin
      class_o = sqlc_pkg::ClsWith;
    end else if (view_i.window_found) begin
      class_o = sqlc_pkg::ClsWindow;
    end else if (view_i.setop_found) begin
      class_o = sqlc_pkg::ClsSetop;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("SHOW"), 5'd4) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("DESC"), 5'd4)) begin
      class_o = sqlc_pkg::ClsShow;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("SET "), 5'd4)) begin
      class_o = sqlc_pkg::ClsSet;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("GRANT"), 5'd5) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("REVOKE"), 5'd6)) begin
      class_o = sqlc_pkg::ClsGrant;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("EXPLAIN"), 5'd7)) begin
      class_o = sqlc_pkg::ClsExplain;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("PREPARE"), 5'd7)) begin
      class_o = sqlc_pkg::ClsPrepare;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("EXECUTE"), 5'd7)) begin
      class_o = sqlc_pkg::ClsExecute;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("PRAGMA"), 5'd6)) begin
      class_o = sqlc_pkg::ClsPragma;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("REINDEX"), 5'd7)) begin
      class_o = sqlc_pkg::ClsReindex;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("CREATE VIEW"), 5'd11) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("CREATE TEMP VIEW"), 5'd16) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("CREATE TEMPORARY VIEW"), 5'd21)) begin
      class_o = sqlc_pkg::ClsCreateView;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("CREATE TRIGGER"), 5'd14)) begin
      class_o = sqlc_pkg::ClsCreateTrigger;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("DROP TRIGGER"), 5'd12)) begin
      class_o = sqlc_pkg::ClsDropTrigger;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("DROP VIEW"), 5'd9)) begin
      class_o = sqlc_pkg::ClsDropView;
    end else if (sqlc_pkg::prefix_hit(st, n, kw_t'("SELECT"), 5'd6) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("INSERT"), 5'd6) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("UPDATE"), 5'd6) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("DELETE"), 5'd6) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("CREATE"), 5'd6) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("DROP"), 5'd4) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("ALTER"), 5'd5) ||
                 sqlc_pkg::prefix_hit(st, n, kw_t'("OPEN"), 5'd4)) begin
      class_o = sqlc_pkg::ClsOltp;
    end else begin
      class_o = sqlc_pkg::ClsUnknown;
    end
  end

endmodule

FILE: hdl/sql_statement_classifier_top.sv
// ----------------------------------------------------------------------------
// sql_statement_classifier_top
// Byte-stream SQL statement classifier with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   stmt_i carries one statement byte per transfer (text_byte, last_byte).
//   class_o carries one class code per statement, after its last byte.
//   Bytes are taken at one per cycle unless a last byte waits on a stalled
//   class_o. A byte is registered on transfer and folded into the statement
//   state as it leaves the input register, which for a last byte loads its
//   class into the output register. Bytes without the last flag never wait.
//   The rate is set by the single pass from the input register through the
//   trim/match logic and the keyword decode into the output register.
//   When class_o stalls, the output register holds the code; the input
//   register keeps accepting bytes until a second last byte reaches it,
//   and stmt_i.ready then drops until the pending code is taken.
//   Reset clears both channel registers and all statement state, so the
//   next byte starts a new statement; the prefix store needs no clearing.
// ----------------------------------------------------------------------------
module sql_statement_classifier_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqlc_in_if.sink    stmt_i,
  sqlc_out_if.source class_o
);

  logic                 in_valid_q;
  logic [7:0]           text_q;
  logic                 last_q;
  logic                 out_valid_q;
  sqlc_pkg::class_e     class_q;
  sqlc_pkg::class_e     class_d;
  sqlc_pkg::sqlc_view_t view;
  logic                 step;

  // Byte is consumed unless it is a last byte facing a full, stalled output
  assign step = in_valid_q && (!last_q || !out_valid_q || class_o.ready);
  assign stmt_i.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (stmt_i.ready) begin
      in_valid_q <= stmt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stmt_i.valid && stmt_i.ready) begin
      text_q <= stmt_i.text_byte;
      last_q <= stmt_i.last_byte;
    end
  end

  sqlc_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (text_q),
    .last_byte_i (last_q),
    .view_o      (view)
  );

  sqlc_classify u_classify (
    .view_i  (view),
    .class_o (class_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
    end else if (class_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) class_q <= class_d;
  end

  assign class_o.valid           = out_valid_q;
  assign class_o.statement_class = class_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stmt_i.ready |-> in_valid_q && last_q && out_valid_q && !class_o.ready)
    else $error("input stalled without a blocked result");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_q |=> out_valid_q)
    else $error("last byte did not produce a result");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> class_q <= sqlc_pkg::ClsUnknown)
    else $error("class code out of range");

  a_no_result_without_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && last_q))
    else $error("result without a last byte");

endmodule

FILE: tb/sql_statement_classifier_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sql_statement_classifier_top_tb
// Self-checking testbench for the byte-stream SQL statement classifier.
// A table of directed statements is followed by random statements, most of
// them keyword-led, some with window or setop fragments, some pure noise.
// Every class code is checked against the in-bench model or a pinned class;
// both channels idle at random, with one long hold-off on the class output.
// ----------------------------------------------------------------------------
module sql_statement_classifier_top_tb;

  localparam int unsigned TotalBytes  = 1450;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumRows     = 32;
  localparam int unsigned NumKw       = 31;
  localparam int unsigned NumInfix    = 8;

  localparam sqlc_pkg::byte_t ChSpace    = 8'h20;
  localparam sqlc_pkg::byte_t ChTab      = 8'h09;
  localparam sqlc_pkg::byte_t ChCr       = 8'h0D;
  localparam sqlc_pkg::byte_t ChLowA     = 8'h61;
  localparam sqlc_pkg::byte_t ChLowZ     = 8'h7A;
  localparam sqlc_pkg::byte_t ChUpA      = 8'h41;
  localparam sqlc_pkg::byte_t ChUpZ      = 8'h5A;
  localparam sqlc_pkg::byte_t CaseOffset = 8'h20;

  typedef sqlc_pkg::byte_t bytes_t[$];

  // Directed row: statement text, and a class pinned by hand where obvious
  typedef struct {
    string            text;
    bit               pinned;
    sqlc_pkg::class_e cls;
  } stmt_row_t;

  typedef struct {
    bit               pinned;
    sqlc_pkg::class_e cls;
  } pin_t;

  logic clk;
  logic rst_n;

  sqlc_in_if  stmt_if ();
  sqlc_out_if class_if ();

  sql_statement_classifier_top u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .stmt_i  (stmt_if),
    .class_o (class_if)
  );

  stmt_row_t dir_rows [NumRows] = '{
    '{" \t\n\013\014\015 ", 1'b1, sqlc_pkg::ClsUnknown},
    '{"\377", 1'b1, sqlc_pkg::ClsUnknown},
    '{"\200select 1", 1'b0, sqlc_pkg::ClsUnknown},
    '{"  begin work  ", 1'b1, sqlc_pkg::ClsBegin},
    '{"Start Transaction", 1'b0, sqlc_pkg::ClsUnknown},
    '{"COMMIT", 1'b1, sqlc_pkg::ClsCommit},
    '{"rollback to s1", 1'b0, sqlc_pkg::ClsUnknown},
    '{"savepoint s1", 1'b0, sqlc_pkg::ClsUnknown},
    '{"release savepoint s1", 1'b0, sqlc_pkg::ClsUnknown},
    '{"with q as (select 1) select * from q", 1'b0, sqlc_pkg::ClsUnknown},
    '{"select rank() from t", 1'b0, sqlc_pkg::ClsUnknown},
    '{"select sum(a) over (partition by b) from t", 1'b0, sqlc_pkg::ClsUnknown},
    '{"select ntile(2) over(order by a)", 1'b0, sqlc_pkg::ClsUnknown},
    '{"select a from t union select b", 1'b0, sqlc_pkg::ClsUnknown},
    '{"select a from t intersect \t ", 1'b0, sqlc_pkg::ClsUnknown},
    '{"a except b", 1'b0, sqlc_pkg::ClsUnknown},
    '{"show tables", 1'b0, sqlc_pkg::ClsUnknown},
    '{"desc t", 1'b0, sqlc_pkg::ClsUnknown},
    '{"set x = 1", 1'b0, sqlc_pkg::ClsUnknown},
    '{"set \t", 1'b0, sqlc_pkg::ClsUnknown},
    '{"revoke all on t", 1'b0, sqlc_pkg::ClsUnknown},
    '{"explain select 1", 1'b0, sqlc_pkg::ClsUnknown},
    '{"prepare p from q", 1'b0, sqlc_pkg::ClsUnknown},
    '{"execute p", 1'b0, sqlc_pkg::ClsUnknown},
    '{"pragma x", 1'b0, sqlc_pkg::ClsUnknown},
    '{"reindex i", 1'b0, sqlc_pkg::ClsUnknown},
    '{"create temp view v", 1'b0, sqlc_pkg::ClsUnknown},
    '{"CREATE TEMPORARY VIEW v", 1'b0, sqlc_pkg::ClsUnknown},
    '{"create trigger tr", 1'b0, sqlc_pkg::ClsUnknown},
    '{"drop trigger tr", 1'b0, sqlc_pkg::ClsUnknown},
    '{"drop view v", 1'b0, sqlc_pkg::ClsUnknown},
    '{"update t set a = 1", 1'b0, sqlc_pkg::ClsUnknown}
  };

  string kw_list [NumKw] = '{
    "BEGIN", "START TRANSACTION", "COMMIT", "ROLLBACK", "SAVEPOINT",
    "RELEASE SAVEPOINT", "WITH", "SHOW", "DESC", "SET ", "GRANT", "REVOKE",
    "EXPLAIN", "PREPARE", "EXECUTE", "PRAGMA", "REINDEX", "CREATE VIEW",
    "CREATE TEMP VIEW", "CREATE TEMPORARY VIEW", "CREATE TRIGGER",
    "DROP TRIGGER", "DROP VIEW", "SELECT", "INSERT", "UPDATE", "DELETE",
    "CREATE", "DROP", "ALTER", "OPEN"
  };

  string infix_list [NumInfix] = '{
    " OVER (", " OVER(", {"ROW_", "NUMBER("}, "RANK(", " UNION ", " INTERSECT ",
    " EXCEPT ", " UNIONS "
  };

  string filler_chars = "SELCT abc_xyz(),*=19\t";
  sqlc_pkg::byte_t blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // Classifier model state
  bit              seen_text;
  sqlc_pkg::byte_t pfx_store [sqlc_pkg::PrefixDepth];
  int unsigned     pfx_len;
  int unsigned     pfx_trim;
  sqlc_pkg::byte_t tail [sqlc_pkg::TailDepth];     // tail[0] is the newest byte
  bit              window_hit;
  bit              setop_armed;
  bit              setop_hit;

  sqlc_pkg::class_e expected_class_q[$];
  pin_t             pinned_q[$];

  bit          quiet;
  bit          hold_req;
  int unsigned holds_done;
  int unsigned errors;
  int unsigned stmts_sent;
  int unsigned bytes_sent;
  bit [20:0]   classes_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Classifier model
  // ---------------------------------------------------------------------------
  function automatic void clear_stmt();
    seen_text   = 1'b0;
    pfx_len     = 0;
    pfx_trim    = 0;
    window_hit  = 1'b0;
    setop_armed = 1'b0;
    setop_hit   = 1'b0;
    foreach (pfx_store[i]) pfx_store[i] = '0;
    foreach (tail[i]) tail[i] = '0;
  endfunction

  function automatic bit starts(string kw);
    if (kw.len() > pfx_trim) return 1'b0;
    for (int i = 0; i < kw.len(); i++)
      if (pfx_store[i] != sqlc_pkg::byte_t'(kw[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit tail_ends(string pat);
    if (pat.len() > sqlc_pkg::TailDepth) return 1'b0;
    for (int i = 0; i < pat.len(); i++)
      if (tail[pat.len() - 1 - i] != sqlc_pkg::byte_t'(pat[i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sqlc_pkg::class_e classify_stmt();
    if (starts("BEGIN") || starts("START TRANSACTION")) return sqlc_pkg::ClsBegin;
    if (starts("COMMIT")) return sqlc_pkg::ClsCommit;
    if (starts("ROLLBACK")) return sqlc_pkg::ClsRollback;
    if (starts("SAVEPOINT") || starts("RELEASE SAVEPOINT")) return sqlc_pkg::ClsSavepoint;
    if (starts("WITH")) return sqlc_pkg::ClsWith;
    if (window_hit) return sqlc_pkg::ClsWindow;
    if (setop_hit) return sqlc_pkg::ClsSetop;
    if (starts("SHOW") || starts("DESC")) return sqlc_pkg::ClsShow;
    if (starts("SET ")) return sqlc_pkg::ClsSet;
    if (starts("GRANT") || starts("REVOKE")) return sqlc_pkg::ClsGrant;
    if (starts("EXPLAIN")) return sqlc_pkg::ClsExplain;
    if (starts("PREPARE")) return sqlc_pkg::ClsPrepare;
    if (starts("EXECUTE")) return sqlc_pkg::ClsExecute;
    if (starts("PRAGMA")) return sqlc_pkg::ClsPragma;
    if (starts("REINDEX")) return sqlc_pkg::ClsReindex;
    if (starts("CREATE VIEW") || starts("CREATE TEMP VIEW") ||
        starts("CREATE TEMPORARY VIEW")) return sqlc_pkg::ClsCreateView;
    if (starts("CREATE TRIGGER")) return sqlc_pkg::ClsCreateTrigger;
    if (starts("DROP TRIGGER")) return sqlc_pkg::ClsDropTrigger;
    if (starts("DROP VIEW")) return sqlc_pkg::ClsDropView;
    if (starts("SELECT") || starts("INSERT") || starts("UPDATE") ||
        starts("DELETE") || starts("CREATE") || starts("DROP") ||
        starts("ALTER") || starts("OPEN")) return sqlc_pkg::ClsOltp;
    return sqlc_pkg::ClsUnknown;
  endfunction

  // Fold one accepted byte into the model; a last byte yields a class
  function automatic void absorb_byte(input sqlc_pkg::byte_t raw, input bit last,
                                      output bit has_cls, output sqlc_pkg::class_e cls);
    sqlc_pkg::byte_t b;
    bit              blank;
    b = raw;
    if (b >= ChLowA && b <= ChLowZ) b = b - CaseOffset;
    blank = (b == ChSpace) || (b >= ChTab && b <= ChCr);
    // leading whitespace is dropped entirely
    if (seen_text || !blank) begin
      seen_text = 1'b1;
      if (pfx_len < sqlc_pkg::PrefixDepth) begin
        pfx_store[pfx_len] = b;
        pfx_len++;
      end
      if (!blank) pfx_trim = pfx_len;
      for (int k = sqlc_pkg::TailDepth - 1; k > 0; k--) tail[k] = tail[k-1];
      tail[0] = b;
      // a set operation counts only once text follows it
      if (!blank && setop_armed) begin
        setop_hit   = 1'b1;
        setop_armed = 1'b0;
      end
      if (tail_ends(" OVER(") || tail_ends(" OVER (") ||
          tail_ends({"ROW_", "NUMBER("}) || tail_ends("RANK("))
        window_hit = 1'b1;
      if (tail_ends(" UNION ") || tail_ends(" INTERSECT ") || tail_ends(" EXCEPT "))
        setop_armed = 1'b1;
    end
    has_cls = last;
    cls     = sqlc_pkg::ClsUnknown;
    if (last) begin
      cls = classify_stmt();
      clear_stmt();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random statements
  // ---------------------------------------------------------------------------
  function automatic sqlc_pkg::byte_t rand_case(sqlc_pkg::byte_t b);
    if (b >= ChUpA && b <= ChUpZ && $urandom_range(0, 1) == 1) return b + CaseOffset;
    return b;
  endfunction

  function automatic void push_text(ref bytes_t s, input string t, input int unsigned n);
    for (int i = 0; i < n; i++) s.push_back(rand_case(sqlc_pkg::byte_t'(t[i])));
  endfunction

  function automatic void push_filler(ref bytes_t s, input int unsigned n);
    repeat (n)
      s.push_back(rand_case(sqlc_pkg::byte_t'(
        filler_chars[$urandom_range(0, filler_chars.len() - 1)])));
  endfunction

  function automatic void push_blanks(ref bytes_t s, input int unsigned n);
    repeat (n) s.push_back(blank_chars[$urandom_range(0, 5)]);
  endfunction

  function automatic bytes_t rand_stmt();
    bytes_t      s;
    string       kw;
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 9);
    // noise: arbitrary byte values
    if (sel == 0) begin
      n = $urandom_range(1, 30);
      repeat (n) s.push_back(sqlc_pkg::byte_t'($urandom_range(0, 255)));
      return s;
    end
    push_blanks(s, $urandom_range(0, 3));
    kw = kw_list[$urandom_range(0, NumKw - 1)];
    // near miss: keyword may be cut short
    n  = (sel == 1) ? $urandom_range(0, kw.len()) : kw.len();
    push_text(s, kw, n);
    push_filler(s, $urandom_range(0, 8));
    if ($urandom_range(0, 2) == 0) begin
      kw = infix_list[$urandom_range(0, NumInfix - 1)];
      push_text(s, kw, kw.len());
    end
    push_filler(s, $urandom_range(0, 12));
    push_blanks(s, $urandom_range(0, 3));
    if (s.size() == 0) s.push_back(sqlc_pkg::byte_t'($urandom_range(0, 255)));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------
  task automatic send_byte(input sqlc_pkg::byte_t b, input bit last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      stmt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stmt_if.valid     <= 1'b1;
    stmt_if.text_byte <= b;
    stmt_if.last_byte <= last;
    do @(posedge clk); while (!stmt_if.ready);
  endtask

  task automatic send_stmt(input bytes_t s, input bit pinned, input sqlc_pkg::class_e cls);
    pinned_q.push_back('{pinned, cls});
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    stmts_sent++;
    bytes_sent += s.size();
  endtask

  function automatic bytes_t text_bytes(string t);
    bytes_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(sqlc_pkg::byte_t'(t[i]));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Class receiver: random hold-off per transfer, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned gap;
    class_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        class_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        class_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      class_if.ready <= 1'b1;
      do @(posedge clk); while (!class_if.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on byte transfers, check on class transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    bit               has_cls;
    sqlc_pkg::class_e cls;
    sqlc_pkg::class_e exp_cls;
    pin_t             pin;
    if (rst_n) begin
      if (stmt_if.valid && stmt_if.ready) begin
        absorb_byte(stmt_if.text_byte, stmt_if.last_byte, has_cls, cls);
        if (has_cls) begin
          pin = pinned_q.pop_front();
          expected_class_q.push_back(pin.pinned ? pin.cls : cls);
        end
      end
      if (class_if.valid && class_if.ready) begin
        if (class_if.statement_class <= 5'd20) classes_seen[class_if.statement_class] = 1'b1;
        if (expected_class_q.size() == 0) begin
          $display("%0t: unexpected class transfer, expected none, got %0d",
                   $time, class_if.statement_class);
          errors++;
        end else begin
          exp_cls = expected_class_q.pop_front();
          if (class_if.statement_class !== exp_cls) begin
            $display("%0t: class mismatch, expected %0d, got %0d",
                     $time, exp_cls, class_if.statement_class);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((stmt_if.valid && stmt_if.ready) || (class_if.valid && class_if.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    holds_done = 0;
    errors     = 0;
    stmts_sent = 0;
    bytes_sent = 0;
    classes_seen = '0;
    clear_stmt();
    stmt_if.valid     <= 1'b0;
    stmt_if.text_byte <= '0;
    stmt_if.last_byte <= 1'b0;
    rst_n             <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[r])
      send_stmt(text_bytes(dir_rows[r].text), dir_rows[r].pinned, dir_rows[r].cls);

    // random statements; one long output hold, one stretch without idling
    n = 0;
    while (bytes_sent < TotalBytes) begin
      if (n == 10) hold_req = 1'b1;
      quiet = (n >= 40 && n < 70);
      send_stmt(rand_stmt(), 1'b0, sqlc_pkg::ClsUnknown);
      n++;
    end
    stmt_if.valid <= 1'b0;
    quiet = 1'b0;

    // drain
    while (expected_class_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Classified %0d statements (%0d bytes), %0d of 21 class codes seen.",
             stmts_sent, bytes_sent, $countones(classes_seen));
    $display("Both channels idled at random; output held off %0d time(s) for %0d cycles.",
             holds_done, HoldCycles);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
